// ===== hdl/albs_pkg.sv =====
// ----------------------------------------------------------------------------
// albs_pkg
// Shared types and constants of the addressable LED bit sequencer.
// ----------------------------------------------------------------------------
package albs_pkg;

    localparam int COLOR_W     = 24;
    localparam int LED_INDEX_W = 6;
    localparam int LED_POS_W   = 7;
    localparam int SLOT_W      = 16;
    localparam int REG_IDX_W   = 3;
    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 32;

    localparam logic [REG_IDX_W-1:0] REG_BIT_PERIOD   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_HIGH_ONE     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_HIGH_ZERO    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_RESET_PERIOD = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_LED_COUNT    = 3'd4;

    localparam logic [SLOT_W-1:0]    RST_BIT_PERIOD   = 16'd160;
    localparam logic [SLOT_W-1:0]    RST_HIGH_ONE     = 16'd100;
    localparam logic [SLOT_W-1:0]    RST_HIGH_ZERO    = 16'd12;
    localparam logic [SLOT_W-1:0]    RST_RESET_PERIOD = 16'h6000;
    localparam logic [LED_POS_W-1:0] RST_LED_COUNT    = 7'd64;

    typedef struct packed {
        logic [SLOT_W-1:0]    bit_period;
        logic [SLOT_W-1:0]    high_one;
        logic [SLOT_W-1:0]    high_zero;
        logic [SLOT_W-1:0]    reset_period;
        logic [LED_POS_W-1:0] led_count;
    } cfg_t;

endpackage

// ===== hdl/albs_ram.sv =====
// ----------------------------------------------------------------------------
// albs_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module albs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/albs_store.sv =====
// ----------------------------------------------------------------------------
// albs_store
// Colour word store: RAM plus per-entry valid bits and write bypass, so the
// word of rd_pos is ready in the cycle after rd_pos is presented.
// ----------------------------------------------------------------------------
module albs_store #(
    parameter int DEPTH = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [albs_pkg::LED_INDEX_W-1:0]  wr_idx,
    input  logic [albs_pkg::COLOR_W-1:0]      wr_data,
    input  logic [albs_pkg::LED_POS_W-1:0]    rd_pos,
    output logic [albs_pkg::COLOR_W-1:0]      rd_word
);
    import albs_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [LED_POS_W-1:0] DEPTH_L = LED_POS_W'(DEPTH);

    logic                 wr_hit;
    logic                 rd_in;
    logic [COLOR_W-1:0]   ram_q;
    logic [DEPTH-1:0]     valid_reg;
    logic                 rdv_reg;
    logic                 rdv_next;
    logic                 byp_reg;
    logic                 byp_next;
    logic [COLOR_W-1:0]   bypd_reg;

    assign wr_hit   = wr_en && ({1'b0, wr_idx} < DEPTH_L);
    assign rd_in    = rd_pos < DEPTH_L;
    assign rdv_next = rd_in && valid_reg[rd_pos[AW-1:0]];
    assign byp_next = wr_hit && ({1'b0, wr_idx} == rd_pos);

    albs_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (wr_hit),
        .waddr (wr_idx[AW-1:0]),
        .wdata (wr_data),
        .raddr (rd_pos[AW-1:0]),
        .rdata (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rdv_reg   <= 1'b0;
            byp_reg   <= 1'b0;
        end
        else
        begin
            if (wr_hit)
            begin
                valid_reg[wr_idx[AW-1:0]] <= 1'b1;
            end
            rdv_reg <= rdv_next;
            byp_reg <= byp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bypd_reg <= wr_data;
    end

    assign rd_word = byp_reg ? bypd_reg : (rdv_reg ? ram_q : '0);

endmodule

// ===== hdl/albs_regs.sv =====
// ----------------------------------------------------------------------------
// albs_regs
// APB configuration registers: slot timing and frame length.
// ----------------------------------------------------------------------------
module albs_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [albs_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [albs_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [albs_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output albs_pkg::cfg_t                   cfg
);
    import albs_pkg::*;

    cfg_t                 cfg_reg;
    logic [REG_IDX_W-1:0] idx;
    logic                 wr;

    assign idx    = paddr[APB_ADDR_W-1:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bit_period   <= RST_BIT_PERIOD;
            cfg_reg.high_one     <= RST_HIGH_ONE;
            cfg_reg.high_zero    <= RST_HIGH_ZERO;
            cfg_reg.reset_period <= RST_RESET_PERIOD;
            cfg_reg.led_count    <= RST_LED_COUNT;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_BIT_PERIOD:   cfg_reg.bit_period   <= pwdata[SLOT_W-1:0];
                REG_HIGH_ONE:     cfg_reg.high_one     <= pwdata[SLOT_W-1:0];
                REG_HIGH_ZERO:    cfg_reg.high_zero    <= pwdata[SLOT_W-1:0];
                REG_RESET_PERIOD: cfg_reg.reset_period <= pwdata[SLOT_W-1:0];
                REG_LED_COUNT:    cfg_reg.led_count    <= pwdata[LED_POS_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_BIT_PERIOD:   prdata = APB_DATA_W'(cfg_reg.bit_period);
            REG_HIGH_ONE:     prdata = APB_DATA_W'(cfg_reg.high_one);
            REG_HIGH_ZERO:    prdata = APB_DATA_W'(cfg_reg.high_zero);
            REG_RESET_PERIOD: prdata = APB_DATA_W'(cfg_reg.reset_period);
            REG_LED_COUNT:    prdata = APB_DATA_W'(cfg_reg.led_count);
            default:          prdata = '0;
        endcase
    end

endmodule

// ===== hdl/addressable_led_bit_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// addressable_led_bit_sequencer_top
// LED strip bit sequencer: stores one colour word per LED and, per timer
// period-end tick, returns period and compare of the next slot.
//
//   channel  dir  handshake                 payload
//   in       in   in_valid / in_ready       func, led_index, color_word
//   out      out  out_valid / out_ready     period, compare, latch_slot
//   cfg      in   psel/penable/pwrite       paddr, pwdata, prdata
//
// One transaction per cycle sustained while tick results are taken; a tick
// result passes the input register, then the result register.
// The store is read ahead at the next LED position, with a write
// bypass, so a write is seen by the very next tick.
// Reset: per-entry valid bits make the store read zero at once, no clear pass.
// A stalled result holds the input register; writes still drain.
// ----------------------------------------------------------------------------
module addressable_led_bit_sequencer_top #(
    parameter int MAX_LEDS     = 64,
    parameter int BITS_PER_LED = 24
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             func,
    input  logic [albs_pkg::LED_INDEX_W-1:0] led_index,
    input  logic [albs_pkg::COLOR_W-1:0]     color_word,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [albs_pkg::SLOT_W-1:0]      period,
    output logic [albs_pkg::SLOT_W-1:0]      compare,
    output logic                             latch_slot,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [albs_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [albs_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [albs_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import albs_pkg::*;

    localparam int STORE_DEPTH = (MAX_LEDS < 2**LED_INDEX_W) ? MAX_LEDS : 2**LED_INDEX_W;
    localparam int BW          = $clog2(BITS_PER_LED);
    localparam int CW          = 11;
    localparam logic [CW-1:0]  MAX_L   = CW'(MAX_LEDS);
    localparam logic [BW-1:0]  LAST_B  = BW'(BITS_PER_LED - 1);
    localparam logic [5:0]     TOP_SEL = 6'(BITS_PER_LED - 1);
    localparam logic [5:0]     COLOR_L = 6'(COLOR_W);

    cfg_t                   cfg;
    logic [COLOR_W-1:0]     cur_word;

    logic                   s1_valid_reg;
    logic                   s1_func_reg;
    logic [LED_INDEX_W-1:0] s1_idx_reg;
    logic [COLOR_W-1:0]     s1_word_reg;
    logic                   s1_go;
    logic                   tick_go;

    logic [LED_POS_W-1:0]   led_pos_reg;
    logic [LED_POS_W-1:0]   led_pos_next;
    logic [BW-1:0]          bit_pos_reg;
    logic [BW-1:0]          bit_pos_next;

    logic [CW-1:0]          count_l;
    logic [CW-1:0]          active_l;
    logic [CW-1:0]          pos_l;
    logic                   in_frame;
    logic [5:0]             bit_sel;
    logic                   bit_value;

    logic                   out_valid_reg;
    logic [SLOT_W-1:0]      period_reg;
    logic [SLOT_W-1:0]      compare_reg;
    logic                   latch_reg;

    albs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    albs_store #(
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (s1_go && !s1_func_reg),
        .wr_idx  (s1_idx_reg),
        .wr_data (s1_word_reg),
        .rd_pos  (led_pos_next),
        .rd_word (cur_word)
    );

    assign s1_go    = s1_valid_reg && (!s1_func_reg || !out_valid_reg || out_ready);
    assign tick_go  = s1_go && s1_func_reg;
    assign in_ready = !s1_valid_reg || s1_go;

    assign count_l   = CW'(cfg.led_count);
    assign active_l  = (count_l > MAX_L) ? MAX_L : count_l;
    assign pos_l     = CW'(led_pos_reg);
    assign in_frame  = (pos_l < active_l) && (pos_l < MAX_L);
    assign bit_sel   = TOP_SEL - 6'(bit_pos_reg);
    assign bit_value = (bit_sel < COLOR_L) ? cur_word[bit_sel[4:0]] : 1'b0;

    always_comb
    begin
        led_pos_next = led_pos_reg;
        bit_pos_next = bit_pos_reg;
        if (tick_go)
        begin
            if (in_frame)
            begin
                if (bit_pos_reg == LAST_B)
                begin
                    bit_pos_next = '0;
                    led_pos_next = led_pos_reg + 1'b1;
                end
                else
                begin
                    bit_pos_next = bit_pos_reg + 1'b1;
                end
            end
            else
            begin
                led_pos_next = '0;
                bit_pos_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            led_pos_reg   <= '0;
            bit_pos_reg   <= '0;
        end
        else
        begin
            led_pos_reg <= led_pos_next;
            bit_pos_reg <= bit_pos_next;
            if (in_valid && in_ready)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (tick_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_func_reg <= func;
            s1_idx_reg  <= led_index;
            s1_word_reg <= color_word;
        end
        if (tick_go)
        begin
            if (in_frame)
            begin
                period_reg  <= cfg.bit_period;
                compare_reg <= bit_value ? cfg.high_one : cfg.high_zero;
                latch_reg   <= 1'b0;
            end
            else
            begin
                period_reg  <= cfg.reset_period;
                compare_reg <= '0;
                latch_reg   <= 1'b1;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign period     = period_reg;
    assign compare    = compare_reg;
    assign latch_slot = latch_reg;

    a_bit_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_pos_reg <= LAST_B)
        else $error("bit position past last bit");

    a_latch_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
        tick_go && !in_frame |=> led_pos_reg == '0 && bit_pos_reg == '0 && latch_slot)
        else $error("latch slot did not rewind the frame");

    a_latch_compare: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && latch_slot |-> compare == '0)
        else $error("latch slot with nonzero compare");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> s1_valid_reg && s1_func_reg && out_valid_reg && !out_ready)
        else $error("input stalled without a blocked tick");

endmodule

// ===== test/tb_addressable_led_bit_sequencer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_addressable_led_bit_sequencer_top
// Self-checking bench for the LED strip bit sequencer. A driver pushes colour
// writes and period-end ticks from a queue, a monitor takes the slot results
// under random backpressure, and a local strip model predicts each slot
// (bit period / high time per data bit, latch slot at frame end). Register
// settings change between drained phases, covering zero, saturated and
// extreme values.
// ----------------------------------------------------------------------------
module tb_addressable_led_bit_sequencer_top;

    import albs_pkg::*;

    localparam logic FUNC_WRITE   = 1'b0;
    localparam logic FUNC_TICK    = 1'b1;
    localparam int   NUM_LEDS     = 64;
    localparam int   BITS_PER_LED = 24;
    localparam int   DRAIN_CYCLES = 8;
    localparam int   IDLE_PCT     = 30;

    typedef struct packed {
        logic                   func;
        logic [LED_INDEX_W-1:0] led_index;
        logic [COLOR_W-1:0]     color_word;
    } strip_cmd_t;

    typedef struct packed {
        logic [SLOT_W-1:0] period;
        logic [SLOT_W-1:0] compare;
        logic              latch_slot;
    } slot_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic                   func;
    logic [LED_INDEX_W-1:0] led_index;
    logic [COLOR_W-1:0]     color_word;
    logic                   out_valid;
    logic                   out_ready;
    logic [SLOT_W-1:0]      period;
    logic [SLOT_W-1:0]      compare;
    logic                   latch_slot;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    strip_cmd_t          pending_cmds[$];
    slot_t               expected_slots[$];
    cfg_t                strip_cfg;
    logic [COLOR_W-1:0]  color_mem[NUM_LEDS];
    int                  led_pos;
    int                  bit_pos;
    bit                  no_gaps;
    int                  errors;
    int                  ticks_sent;
    int                  writes_sent;
    int                  slots_seen;
    int                  latches_seen;
    int                  phases_run;

    addressable_led_bit_sequencer_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .led_index  (led_index),
        .color_word (color_word),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .period     (period),
        .compare    (compare),
        .latch_slot (latch_slot),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        func       = FUNC_WRITE;
        led_index  = '0;
        color_word = '0;
        out_ready  = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    // strip model: one slot per tick, none per write
    function automatic void advance_strip(input strip_cmd_t cmd);
        slot_t s;
        int    active;
        if (cmd.func == FUNC_WRITE)
        begin
            color_mem[cmd.led_index] = cmd.color_word;
            writes_sent++;
            return;
        end
        active = (strip_cfg.led_count > NUM_LEDS) ? NUM_LEDS : int'(strip_cfg.led_count);
        if (led_pos < active)
        begin
            s.period     = strip_cfg.bit_period;
            s.compare    = color_mem[led_pos][BITS_PER_LED-1-bit_pos] ?
                           strip_cfg.high_one : strip_cfg.high_zero;
            s.latch_slot = 1'b0;
            bit_pos++;
            if (bit_pos == BITS_PER_LED)
            begin
                bit_pos = 0;
                led_pos++;
            end
        end
        else
        begin
            s.period     = strip_cfg.reset_period;
            s.compare    = '0;
            s.latch_slot = 1'b1;
            led_pos      = 0;
            bit_pos      = 0;
        end
        expected_slots.push_back(s);
        ticks_sent++;
    endfunction

    // driver
    always @(posedge clk)
    begin : drive_cmds
        bit took;
        took = 1'b0;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                advance_strip(pending_cmds.pop_front());
                took = 1'b1;
            end
            if (!in_valid || took)
            begin
                if (pending_cmds.size() > 0 &&
                    (no_gaps || $urandom_range(99) >= IDLE_PCT))
                begin
                    in_valid   <= 1'b1;
                    func       <= pending_cmds[0].func;
                    led_index  <= pending_cmds[0].led_index;
                    color_word <= pending_cmds[0].color_word;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin : check_slots
        slot_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                slots_seen++;
                if (latch_slot)
                    latches_seen++;
                if (expected_slots.size() == 0)
                begin
                    $error("unexpected slot: period %0d compare %0d latch_slot %0d",
                           period, compare, latch_slot);
                    errors++;
                end
                else
                begin
                    want = expected_slots.pop_front();
                    if (period !== want.period)
                    begin
                        $error("period: expected %0d, got %0d", want.period, period);
                        errors++;
                    end
                    if (compare !== want.compare)
                    begin
                        $error("compare: expected %0d, got %0d", want.compare, compare);
                        errors++;
                    end
                    if (latch_slot !== want.latch_slot)
                    begin
                        $error("latch_slot: expected %0d, got %0d",
                               want.latch_slot, latch_slot);
                        errors++;
                    end
                end
            end
            out_ready <= no_gaps || $urandom_range(99) >= IDLE_PCT;
        end
    end

    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [15:0] value);
        logic [APB_DATA_W-1:0] wdata;
        wdata       = $urandom;
        wdata[15:0] = value;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_BIT_PERIOD:   strip_cfg.bit_period   = value;
            REG_HIGH_ONE:     strip_cfg.high_one     = value;
            REG_HIGH_ZERO:    strip_cfg.high_zero    = value;
            REG_RESET_PERIOD: strip_cfg.reset_period = value;
            REG_LED_COUNT:    strip_cfg.led_count    = value[LED_POS_W-1:0];
            default: ;
        endcase
    endtask

    function automatic void push_tick();
        strip_cmd_t c;
        c.func       = FUNC_TICK;
        c.led_index  = LED_INDEX_W'($urandom);
        c.color_word = COLOR_W'($urandom);
        pending_cmds.push_back(c);
    endfunction

    function automatic void push_color(input logic [LED_INDEX_W-1:0] idx,
                                       input logic [COLOR_W-1:0] word);
        strip_cmd_t c;
        c.func       = FUNC_WRITE;
        c.led_index  = idx;
        c.color_word = word;
        pending_cmds.push_back(c);
    endfunction

    function automatic logic [COLOR_W-1:0] pick_color();
        case ($urandom_range(4))
            0:       return '0;
            1:       return 24'hFFFFFF;
            default: return COLOR_W'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick16();
        case ($urandom_range(3))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(1, 16'hFFFE));
        endcase
    endfunction

    // sender holds off until every slot is back, then lets the pipe settle
    task automatic wait_drained();
        while (pending_cmds.size() != 0 || expected_slots.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_random_phase(input int n, input int tick_pct);
        int active;
        int k;
        active = (strip_cfg.led_count > NUM_LEDS) ? NUM_LEDS : int'(strip_cfg.led_count);
        @(negedge clk);
        for (k = 0; k < n; k++)
        begin
            if ($urandom_range(99) < tick_pct)
                push_tick();
            else if (active > 0 && $urandom_range(3) != 0)
                push_color(LED_INDEX_W'($urandom_range(active - 1)), pick_color());
            else
                push_color(LED_INDEX_W'($urandom_range(NUM_LEDS - 1)), pick_color());
        end
        wait_drained();
        phases_run++;
    endtask

    initial
    begin : stimulus
        int p;
        int phase_leds[7];
        phase_leds = '{1, 3, 2, 4, 0, 64, 127};
        strip_cfg.bit_period   = RST_BIT_PERIOD;
        strip_cfg.high_one     = RST_HIGH_ONE;
        strip_cfg.high_zero    = RST_HIGH_ZERO;
        strip_cfg.reset_period = RST_RESET_PERIOD;
        strip_cfg.led_count    = RST_LED_COUNT;
        foreach (color_mem[i])
            color_mem[i] = '0;
        led_pos      = 0;
        bit_pos      = 0;
        no_gaps      = 1'b0;
        errors       = 0;
        ticks_sent   = 0;
        writes_sent  = 0;
        slots_seen   = 0;
        latches_seen = 0;
        phases_run   = 0;

        wait (rst_n === 1'b1);
        @(negedge clk);

        // reset values, cleared store, write seen by the next tick
        push_tick();
        push_color(6'd0, 24'hFFFFFF);
        push_tick();
        push_tick();
        push_color(6'd0, 24'h000000);
        push_tick();
        push_color(6'd0, 24'h800001);
        push_color(6'd63, 24'hFFFFFF);
        push_color(6'd1, 24'hA5A5A5);
        push_tick();
        push_tick();
        wait_drained();

        // empty frame with zero latch period
        apb_write(REG_LED_COUNT, 16'd0);
        apb_write(REG_RESET_PERIOD, 16'h0000);
        @(negedge clk);
        push_tick();
        push_color(6'd0, 24'hFFFFFF);
        push_tick();
        push_tick();
        wait_drained();

        for (p = 0; p < 7; p++)
        begin
            case (p)
                0:
                begin
                    apb_write(REG_BIT_PERIOD, 16'hFFFF);
                    apb_write(REG_HIGH_ONE, 16'hFFFF);
                    apb_write(REG_HIGH_ZERO, 16'h0000);
                    apb_write(REG_RESET_PERIOD, 16'hFFFF);
                end
                1:
                begin
                    apb_write(REG_BIT_PERIOD, 16'h0001);
                    apb_write(REG_HIGH_ONE, 16'h0000);
                    apb_write(REG_HIGH_ZERO, 16'hFFFF);
                    apb_write(REG_RESET_PERIOD, 16'h0001);
                end
                default:
                begin
                    apb_write(REG_BIT_PERIOD, pick16());
                    apb_write(REG_HIGH_ONE, pick16());
                    apb_write(REG_HIGH_ZERO, pick16());
                    apb_write(REG_RESET_PERIOD, pick16());
                end
            endcase
            apb_write(REG_LED_COUNT, 16'(phase_leds[p]));
            no_gaps = (p == 3);
            // last phase: led_count saturates, needs a full 64-LED frame
            run_random_phase((p == 6) ? 1560 : 40, (p == 6) ? 99 : 80);
        end
        no_gaps = 1'b0;

        $display("ran %0d config phases: %0d ticks, %0d colour writes", phases_run,
                 ticks_sent, writes_sent);
        $display("checked %0d slot transactions, %0d latch slots, %0d errors",
                 slots_seen, latches_seen, errors);
        if (errors == 0 && expected_slots.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout");
        $display("== FAIL ==");
        $finish;
    end

endmodule
